>>> sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Banner service classifier package
// Shared types and codes for the byte window cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned ByteW = 8;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [4:0] {
    SvcUnknown = 5'd0,
    SvcSsh     = 5'd2,
    SvcHttp    = 5'd6,
    SvcPop3    = 5'd7,
    SvcImap    = 5'd8,
    SvcMysql   = 5'd11,
    SvcFtpSmtp = 5'd18
  } service_e;

  localparam int unsigned SeenSsh   = 0;
  localparam int unsigned Seen220   = 1;
  localparam int unsigned SeenHttp  = 2;
  localparam int unsigned SeenMysql = 3;
  localparam int unsigned SeenPlus  = 4;
  localparam int unsigned SeenStar  = 5;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/bsc_byte_cell.sv
// ----------------------------------------------------------------------------
// Banner window byte cell
// One byte of the recent-byte window, loaded on a shift, zeroed on a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_byte_cell
  import bsc_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire byte_t      byte_i,
  output byte_t           byte_o
);

  byte_t byte_q;
  byte_t byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

>>> sv/banner_service_classifier_unit.sv
// ----------------------------------------------------------------------------
// Banner service classifier
// Classifies a received service banner by port and text signatures.
// ----------------------------------------------------------------------------
// A banner byte is taken per item, every ready cycle, with port and open flag;
// a row of four byte cells holds the recent window and the signature compare
// against it and the incoming byte finishes in the same cycle. On the item
// marked last the service code and line length are loaded into the output
// register at the edge that takes that item and are offered from the next
// cycle, and all state is cleared, so the next banner may start right away.
// Input is taken whenever the output register is empty or its item is taken
// in the same cycle. Bytes after a NUL, and bytes beyond BUFFER_SIZE-1, are
// ignored. Only the port and open flag on the last item are used.
`default_nettype none

module banner_service_classifier_unit
  import bsc_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // port[15:0], is_open[16], banner_byte[24:17], zero fill
  input  wire  [31:0] s_axis_tdata,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // service[4:0], banner_line_length[12:5], zero fill
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned NumCells = 4;
  localparam int unsigned CntW     = $clog2(BUFFER_SIZE);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_SIZE - 1);

  localparam logic [31:0] SigSsh   = 32'h5353482D;
  localparam logic [31:0] Sig220   = 32'h32323020;
  localparam logic [39:0] SigHttp  = 40'h485454502F;
  localparam logic [39:0] SigMysql = 40'h4D7953514C;
  localparam logic [23:0] SigPlus  = 24'h2B4F4B;
  localparam logic [31:0] SigStar  = 32'h2A204F4B;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  localparam logic [15:0] PortTable [17] = '{
    16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd80, 16'd110, 16'd143,
    16'd443, 16'd445, 16'd3306, 16'd3389, 16'd5432, 16'd6379, 16'd8080,
    16'd8443, 16'd27017
  };

  function automatic logic [4:0] port_default(input logic [15:0] port);
    logic [4:0] svc;
    svc = '0;
    for (int i = 0; i < 17; i++) begin
      if (PortTable[i] == port) begin
        svc = 5'(i + 1);
      end
    end
    return svc;
  endfunction

  logic [15:0] in_port;
  logic        in_open;
  byte_t       in_byte;

  assign in_port = s_axis_tdata[15:0];
  assign in_open = s_axis_tdata[16];
  assign in_byte = s_axis_tdata[24:17];

  logic accept;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [5:0]      sig_q, sig_d;
  logic            ended_q, ended_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      len_q, len_d;
  logic            closed_q, closed_d;

  logic       out_valid_q, out_valid_d;
  logic [4:0] out_svc_q, out_svc_d;
  logic [7:0] out_len_q, out_len_d;

  logic       live;
  logic       take;
  cell_ctrl_t ctrl;
  byte_t      win [NumCells];
  logic [39:0] w;

  assign live = accept && !ended_q && (cnt_q < CntMax);
  assign take = live && (in_byte != '0);
  assign ctrl.shift = take;
  assign ctrl.clear = accept && s_axis_tlast;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    bsc_byte_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i ((g == 0) ? in_byte : win[(g == 0) ? 0 : g - 1]),
      .byte_o (win[g])
    );
  end

  assign w = {win[3], win[2], win[1], win[0], in_byte};

  always_comb begin
    logic [5:0]      sig_n;
    logic            ended_n;
    logic [CntW-1:0] cnt_n;
    logic [7:0]      len_n;
    logic            closed_n;
    logic [4:0]      svc;

    sig_n    = sig_q;
    ended_n  = ended_q;
    cnt_n    = cnt_q;
    len_n    = len_q;
    closed_n = closed_q;

    if (live && (in_byte == '0)) begin
      ended_n = 1'b1;
    end
    if (take) begin
      cnt_n = cnt_q + 1'b1;
      if (w[31:0] == SigSsh)   sig_n[SeenSsh]   = 1'b1;
      if (w[31:0] == Sig220)   sig_n[Seen220]   = 1'b1;
      if (w == SigHttp)        sig_n[SeenHttp]  = 1'b1;
      if (w == SigMysql)       sig_n[SeenMysql] = 1'b1;
      if (w[23:0] == SigPlus)  sig_n[SeenPlus]  = 1'b1;
      if (w[31:0] == SigStar)  sig_n[SeenStar]  = 1'b1;
      if (!closed_q) begin
        if (in_byte == ChCr || in_byte == ChLf) begin
          closed_n = 1'b1;
        end else if (len_q != 8'hFF) begin
          len_n = len_q + 1'b1;
        end
      end
    end

    svc = port_default(in_port);
    if (in_open) begin
      if (sig_n[SeenSsh])   svc = SvcSsh;
      if (sig_n[Seen220])   svc = SvcFtpSmtp;
      if (sig_n[SeenHttp])  svc = SvcHttp;
      if (sig_n[SeenMysql]) svc = SvcMysql;
      if (sig_n[SeenPlus])  svc = SvcPop3;
      if (sig_n[SeenStar])  svc = SvcImap;
    end

    out_valid_d = m_axis_tvalid && !m_axis_tready;
    out_svc_d   = out_svc_q;
    out_len_d   = out_len_q;
    if (ctrl.clear) begin
      out_valid_d = 1'b1;
      out_svc_d   = svc;
      out_len_d   = (in_open && closed_n) ? len_n : 8'd0;
      sig_n    = '0;
      ended_n  = 1'b0;
      cnt_n    = '0;
      len_n    = '0;
      closed_n = 1'b0;
    end

    sig_d    = sig_n;
    ended_d  = ended_n;
    cnt_d    = cnt_n;
    len_d    = len_n;
    closed_d = closed_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q       <= '0;
      ended_q     <= 1'b0;
      cnt_q       <= '0;
      len_q       <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sig_q       <= sig_d;
      ended_q     <= ended_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_svc_q <= out_svc_d;
    out_len_q <= out_len_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_len_q, out_svc_q};

endmodule

`default_nettype wire
